FILE: hw/rtl/rde_pkg.sv
// rde_pkg: shared types and constants for the reversible deque engine
// depends on nothing; used by rde_ctrl and reversible_deque_engine
`default_nettype none

package rde_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 31;
  localparam int KIND_W    = 2;
  localparam int ST_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_REVERSE = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_EMIT    = 2'd3
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_ELEMENT = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  // output stage load request from the sequencer
  typedef struct packed {
    logic    load;
    logic    from_mem;
    status_t status;
    logic    last;
  } load_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rde_ram.sv
// rde_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module rde_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rde_ctrl.sv
// rde_ctrl: ring pointers, direction and error flags, and the emit drain sequencer
// depends on rde_pkg; drives the ports of one rde_ram
`default_nettype none

module rde_ctrl #(
  parameter int DEPTH = rde_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [rde_pkg::KIND_W-1:0] in_kind,
  input  wire logic [rde_pkg::VAL_W-1:0]  in_value,
  output logic                           in_stall,
  input  wire logic                      out_free,
  output rde_pkg::load_t                 load,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [rde_pkg::VAL_W-1:0]      wr_data,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_DRAIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     rev_r, rev_nxt;
  logic                     err_r, err_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic                     pend_last_r, pend_last_nxt;
  rde_pkg::status_t         st_r, st_nxt;
  logic                     in_fire;
  logic                     xfer;
  logic                     issue;
  logic [CW-1:0]            off;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && (state_r == S_IDLE);

  assign xfer  = (state_r == S_DRAIN) && pend_r && out_free;
  assign issue = (state_r == S_DRAIN) && (idx_r != count_r) && (!pend_r || xfer);
  assign off   = rev_r ? (count_r - CW'(1) - idx_r) : idx_r;

  assign rd_en   = issue;
  assign rd_addr = slot_of(head_r, off);
  assign wr_addr = slot_of(head_r, count_r);
  assign wr_data = in_value;
  assign wr_en   = in_fire && (rde_pkg::kind_t'(in_kind) == rde_pkg::KIND_PUSH)
                   && (count_r < CW'(DEPTH));

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    st_nxt        = st_r;
    load.load     = 1'b0;
    load.from_mem = 1'b0;
    load.status   = rde_pkg::ST_ELEMENT;
    load.last     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (rde_pkg::kind_t'(in_kind))
            rde_pkg::KIND_PUSH: begin
              if (count_r < CW'(DEPTH)) begin
                count_nxt = count_r + CW'(1);
              end else begin
                err_nxt = 1'b1;
              end
            end
            rde_pkg::KIND_REVERSE: begin
              rev_nxt = !rev_r;
            end
            rde_pkg::KIND_DELETE: begin
              if (!err_r) begin
                if (count_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  if (!rev_r) begin
                    head_nxt = slot_of(head_r, CW'(1));
                  end
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            rde_pkg::KIND_EMIT: begin
              if (err_r) begin
                st_nxt    = rde_pkg::ST_ERROR;
                state_nxt = S_SINGLE;
              end else if (count_r == '0) begin
                st_nxt    = rde_pkg::ST_EMPTY;
                state_nxt = S_SINGLE;
              end else begin
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_DRAIN;
              end
            end
          endcase
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          load.load   = 1'b1;
          load.status = st_r;
          load.last   = 1'b1;
          head_nxt    = '0;
          count_nxt   = '0;
          rev_nxt     = 1'b0;
          err_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      S_DRAIN: begin
        load.load     = xfer;
        load.from_mem = 1'b1;
        load.last     = pend_last_r;
        if (issue) begin
          idx_nxt       = idx_r + CW'(1);
          pend_nxt      = 1'b1;
          pend_last_nxt = (idx_r == count_r - CW'(1));
        end else if (xfer) begin
          pend_nxt = 1'b0;
        end
        if (xfer && pend_last_r) begin
          pend_nxt  = 1'b0;
          head_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      st_r        <= rde_pkg::ST_EMPTY;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      st_r        <= st_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !wr_en)
    else $error("ram written while draining");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.load |-> out_free)
    else $error("output stage loaded while occupied");

  a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_DRAIN))
    else $error("read pending outside drain");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && pend_last_r) |=> (count_r == '0) && !err_r && !rev_r && (state_r == S_IDLE))
    else $error("queue not cleared after emit");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/reversible_deque_engine.sv
// reversible_deque_engine: push, reverse and delete give no word.
// an emit stalls the input until its last word is loaded (n held elements, one word per
// cycle through the ram read port unless the output stalls, or a status word for empty or
// error); element words go through the ram read register, then the output register.
// synchronous active-low reset clears pointers, flags and output valid; ram contents
// are left as they are, no clearing pass
`default_nettype none

module reversible_deque_engine #(
  parameter int DEPTH = rde_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rde_pkg::KIND_W-1:0] in_kind,
  input  wire logic [rde_pkg::VAL_W-1:0]  in_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rde_pkg::VAL_W-1:0]       out_element,
  output logic [rde_pkg::ST_W-1:0]        out_status,
  output logic                            out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rde_pkg::load_t              load;
  logic                        out_free;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [rde_pkg::VAL_W-1:0]   wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [rde_pkg::VAL_W-1:0]   rd_data;
  logic                        out_valid_r;
  logic [rde_pkg::VAL_W-1:0]   out_element_r;
  rde_pkg::status_t            out_status_r;
  logic                        out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  rde_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_kind (in_kind),
    .in_value(in_value),
    .in_stall(in_stall),
    .out_free(out_free),
    .load    (load),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  rde_ram #(
    .WIDTH(rde_pkg::VAL_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load.load) begin
      out_element_r <= load.from_mem ? rd_data : '0;
      out_status_r  <= load.status;
      out_last_r    <= load.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_element = out_element_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_element_r) && $stable(out_last_r))
    else $error("stalled output word changed");

  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != rde_pkg::ST_ELEMENT)) |-> (out_element_r == '0) && out_last_r)
    else $error("status word carries element or lacks last");

  a_no_accept_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    load.load |-> in_stall)
    else $error("output loaded while input open");
`endif

endmodule

`default_nettype wire
